// ===== hw/rtl/rwfp_pkg.sv =====
// shared types and constants for the riff/wave format id parser
// no dependencies; used by every module under hw/rtl

package rwfp_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned FMT_W    = 16;
    localparam int unsigned STATUS_W = 3;
    localparam int unsigned TAG_W    = 32;
    localparam int unsigned SKIP_W   = 33;
    localparam int unsigned CNT_W    = 2;

    localparam logic [TAG_W-1:0] TAG_RIFF = 32'h5249_4646;
    localparam logic [TAG_W-1:0] TAG_WAVE = 32'h5741_5645;
    localparam logic [TAG_W-1:0] TAG_FMT  = 32'h666D_7420;
    localparam logic [TAG_W-1:0] TAG_DATA = 32'h6461_7461;

    // parse steps, one-hot
    typedef enum logic [8:0] {
        PH_WAIT  = 9'b0_0000_0001,
        PH_RIFF  = 9'b0_0000_0010,
        PH_SIZE  = 9'b0_0000_0100,
        PH_WAVE  = 9'b0_0000_1000,
        PH_CID   = 9'b0_0001_0000,
        PH_CLEN  = 9'b0_0010_0000,
        PH_FMTLO = 9'b0_0100_0000,
        PH_FMTHI = 9'b0_1000_0000,
        PH_SKIP  = 9'b1_0000_0000
    } t_phase;

    typedef enum logic [STATUS_W-1:0] {
        ST_FOUND    = 3'd0,
        ST_NOT_RIFF = 3'd1,
        ST_NOT_WAVE = 3'd2,
        ST_DATA     = 3'd3,
        ST_TRUNC    = 3'd4
    } t_status;

    typedef struct packed {
        logic [BYTE_W-1:0] byte_value;
        logic              first_of_file;
        logic              last_of_file;
    } t_item;

    typedef struct packed {
        logic             valid;
        logic [FMT_W-1:0] format_id;
        t_status          status;
    } t_result;

endpackage

// ===== hw/rtl/riff_wave_format_id_parser_unit.sv =====
// top level of the riff/wave format id parser: input stage, parser core, output stage
// depends on rwfp_pkg, rwfp_in_stage, rwfp_core, rwfp_out_stage
//
//  channel   dir  tdata                              tuser          tlast
//  s_axis    in   [7:0] byte_value                   first_of_file  last_of_file
//  m_axis    out  [15:0] format_id, [18:16] status   -              -
//
// one byte per cycle sustained unless m_axis stalls; a byte waits in the input register,
// is parsed as it leaves it, and its result (if any) shows in the cycle after
// the parse state updates once per byte, set by the combinational next-state logic
// i_rst_n is synchronous; after reset bytes are ignored until one carries tuser
// a stalled m_axis only holds the input stage when a result is waiting and the
// input register is also full

module riff_wave_format_id_parser_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] byte_value
    input  logic        s_axis_tuser,   // [0] first_of_file
    input  logic        s_axis_tlast,   // last_of_file

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata    // [15:0] format_id, [18:16] status, [23:19] zero
);

    rwfp_pkg::t_item   in_item;
    rwfp_pkg::t_item   st_item;
    logic              st_valid;
    logic              out_free;
    logic              take;
    rwfp_pkg::t_result core_res;
    rwfp_pkg::t_result out_res;

    assign in_item.byte_value    = s_axis_tdata;
    assign in_item.first_of_file = s_axis_tuser;
    assign in_item.last_of_file  = s_axis_tlast;

    // a byte leaves the input register whenever the result register can take its result
    assign take = st_valid && out_free;

    rwfp_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_item  (in_item),
        .i_take  (take),
        .o_valid (st_valid),
        .o_item  (st_item)
    );

    rwfp_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (take),
        .i_item   (st_item),
        .o_result (core_res)
    );

    rwfp_out_stage u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_result (core_res),
        .i_ready  (m_axis_tready),
        .o_free   (out_free),
        .o_result (out_res)
    );

    assign m_axis_tvalid = out_res.valid;
    assign m_axis_tdata  = {5'b0, out_res.status, out_res.format_id};

    // only a found result carries a format id
    a_fmt_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tdata[18:16] != rwfp_pkg::ST_FOUND)
        |-> m_axis_tdata[15:0] == 16'd0)
        else $error("format id nonzero on a failure status");

    // status stays within the defined codes
    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[18:16] <= rwfp_pkg::ST_TRUNC)
        else $error("undefined status code");

    // no result can appear in the cycle right after reset
    a_quiet_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result right after reset");

endmodule

// ===== hw/rtl/rwfp_in_stage.sv =====
// input register stage: holds one accepted byte until the parser consumes it
// depends on rwfp_pkg

module rwfp_in_stage (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  rwfp_pkg::t_item i_item,
    input  logic          i_take,
    output logic          o_valid,
    output rwfp_pkg::t_item o_item
);

    logic            r_valid;
    rwfp_pkg::t_item r_item;

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule

// ===== hw/rtl/rwfp_core.sv =====
// parse state and per-byte next-state logic, one byte per cycle while i_fire is high
// depends on rwfp_pkg

module rwfp_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  rwfp_pkg::t_item   i_item,
    output rwfp_pkg::t_result o_result
);

    rwfp_pkg::t_phase                 r_phase, n_phase;
    logic [rwfp_pkg::CNT_W-1:0]       r_cnt, n_cnt;
    logic [rwfp_pkg::TAG_W-1:0]       r_tag, n_tag;
    logic [rwfp_pkg::TAG_W-1:0]       r_len, n_len;
    logic [rwfp_pkg::SKIP_W-1:0]      r_skip, n_skip;
    logic [rwfp_pkg::BYTE_W-1:0]      r_fmtlo, n_fmtlo;

    rwfp_pkg::t_phase                 ph;
    logic [rwfp_pkg::CNT_W-1:0]       cnt;
    logic [rwfp_pkg::TAG_W-1:0]       tag, len, tag_sh, len_sh;
    logic [rwfp_pkg::SKIP_W-1:0]      skip, padded;
    logic [rwfp_pkg::BYTE_W-1:0]      fmtlo, b;
    logic                             cnt_done;
    rwfp_pkg::t_result                res;

    assign o_result = res;

    always_comb begin
        b       = i_item.byte_value;
        // a file start restarts the parse with this byte as byte 0
        ph      = i_item.first_of_file ? rwfp_pkg::PH_RIFF : r_phase;
        cnt     = i_item.first_of_file ? '0 : r_cnt;
        tag     = i_item.first_of_file ? '0 : r_tag;
        len     = i_item.first_of_file ? '0 : r_len;
        skip    = i_item.first_of_file ? '0 : r_skip;
        fmtlo   = i_item.first_of_file ? '0 : r_fmtlo;

        tag_sh   = {tag[rwfp_pkg::TAG_W-9:0], b};
        len_sh   = {b, len[rwfp_pkg::TAG_W-1:8]};
        cnt_done = (cnt == 2'd3);
        padded   = {1'b0, len_sh} + {{(rwfp_pkg::SKIP_W-1){1'b0}}, len_sh[0]};

        n_phase = ph;
        n_cnt   = cnt;
        n_tag   = tag;
        n_len   = len;
        n_skip  = skip;
        n_fmtlo = fmtlo;

        res           = '0;
        res.status    = rwfp_pkg::ST_FOUND;

        case (ph)
            rwfp_pkg::PH_RIFF: begin
                n_tag = tag_sh;
                n_cnt = cnt_done ? '0 : cnt + 2'd1;
                if (cnt_done) begin
                    if (tag_sh != rwfp_pkg::TAG_RIFF) begin
                        res.valid  = 1'b1;
                        res.status = rwfp_pkg::ST_NOT_RIFF;
                        n_phase    = rwfp_pkg::PH_WAIT;
                    end else begin
                        n_phase = rwfp_pkg::PH_SIZE;
                    end
                end
            end
            rwfp_pkg::PH_SIZE: begin
                n_cnt = cnt_done ? '0 : cnt + 2'd1;
                if (cnt_done) begin
                    n_phase = rwfp_pkg::PH_WAVE;
                end
            end
            rwfp_pkg::PH_WAVE: begin
                n_tag = tag_sh;
                n_cnt = cnt_done ? '0 : cnt + 2'd1;
                if (cnt_done) begin
                    if (tag_sh != rwfp_pkg::TAG_WAVE) begin
                        res.valid  = 1'b1;
                        res.status = rwfp_pkg::ST_NOT_WAVE;
                        n_phase    = rwfp_pkg::PH_WAIT;
                    end else begin
                        n_phase = rwfp_pkg::PH_CID;
                    end
                end
            end
            rwfp_pkg::PH_CID: begin
                n_tag = tag_sh;
                n_cnt = cnt_done ? '0 : cnt + 2'd1;
                if (cnt_done) begin
                    n_phase = rwfp_pkg::PH_CLEN;
                end
            end
            rwfp_pkg::PH_CLEN: begin
                n_len = len_sh;
                n_cnt = cnt_done ? '0 : cnt + 2'd1;
                if (cnt_done) begin
                    // padded length is even, so nonzero means at least 2
                    if (len_sh != '0 && tag == rwfp_pkg::TAG_FMT) begin
                        n_phase = rwfp_pkg::PH_FMTLO;
                    end else if (tag == rwfp_pkg::TAG_DATA) begin
                        res.valid  = 1'b1;
                        res.status = rwfp_pkg::ST_DATA;
                        n_phase    = rwfp_pkg::PH_WAIT;
                    end else if (len_sh == '0) begin
                        n_phase = rwfp_pkg::PH_CID;
                    end else begin
                        n_skip  = padded;
                        n_phase = rwfp_pkg::PH_SKIP;
                    end
                end
            end
            rwfp_pkg::PH_FMTLO: begin
                n_fmtlo = b;
                n_phase = rwfp_pkg::PH_FMTHI;
            end
            rwfp_pkg::PH_FMTHI: begin
                res.valid     = 1'b1;
                res.format_id = {b, fmtlo};
                res.status    = rwfp_pkg::ST_FOUND;
                n_phase       = rwfp_pkg::PH_WAIT;
            end
            rwfp_pkg::PH_SKIP: begin
                n_skip = skip - {{(rwfp_pkg::SKIP_W-1){1'b0}}, 1'b1};
                if (skip == {{(rwfp_pkg::SKIP_W-1){1'b0}}, 1'b1}) begin
                    n_phase = rwfp_pkg::PH_CID;
                end
            end
            default: begin
                n_phase = rwfp_pkg::PH_WAIT;
            end
        endcase

        // end of file with no decision yet
        if (ph != rwfp_pkg::PH_WAIT && n_phase != rwfp_pkg::PH_WAIT
            && i_item.last_of_file) begin
            res.valid     = 1'b1;
            res.format_id = '0;
            res.status    = rwfp_pkg::ST_TRUNC;
            n_phase       = rwfp_pkg::PH_WAIT;
        end

        if (!i_fire) begin
            res.valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= rwfp_pkg::PH_WAIT;
            r_cnt   <= '0;
            r_tag   <= '0;
            r_len   <= '0;
            r_skip  <= '0;
            r_fmtlo <= '0;
        end else if (i_fire) begin
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
            r_tag   <= n_tag;
            r_len   <= n_len;
            r_skip  <= n_skip;
            r_fmtlo <= n_fmtlo;
        end
    end

endmodule

// ===== hw/rtl/rwfp_out_stage.sv =====
// output register: holds one result until the downstream side takes it
// depends on rwfp_pkg

module rwfp_out_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rwfp_pkg::t_result i_result,
    input  logic              i_ready,
    output logic              o_free,
    output rwfp_pkg::t_result o_result
);

    logic                         r_valid;
    logic [rwfp_pkg::FMT_W-1:0]   r_format_id;
    rwfp_pkg::t_status            r_status;

    assign o_free             = !r_valid || i_ready;
    assign o_result.valid     = r_valid;
    assign o_result.format_id = r_format_id;
    assign o_result.status    = r_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_result.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_result.valid) begin
            r_format_id <= i_result.format_id;
            r_status    <= i_result.status;
        end
    end

endmodule
